/* sv/hufd_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Shared sizes, entry layout constants and input/result codes.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int NODE_SLOTS  = 512;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_AW  = $clog2(NODE_SLOTS);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int USED_W   = $clog2(NODE_SLOTS + 1);
    localparam int LEVEL_W  = $clog2(STACK_DEPTH + 1);

    // node entry: leaf flag, left child, right child (leaf value in low byte)
    localparam int IDX_W   = 9;
    localparam int ENTRY_W = 1 + 2 * IDX_W;
    // stack entry: left attached, left child, node index
    localparam int STK_W   = 1 + 2 * IDX_W;

    typedef enum logic [1:0] {
        MODE_TREE     = 2'd0,
        MODE_DATA     = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_RESERVED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SYMBOL    = 2'd0,
        KIND_TREE_OK   = 2'd1,
        KIND_TREE_BAD  = 2'd2,
        KIND_NO_TREE   = 2'd3
    } kind_t;

endpackage

/* sv/hufd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/huffman_tree_decoder.sv */
// ----------------------------------------------------------------------------
// Huffman tree decoder
// Loads a pre-order serialized code tree and walks data bytes through it.
// ----------------------------------------------------------------------------
// Input words: s_tuser selects tree byte, data byte or clear; s_tdata holds
// the byte, taken MSB first; s_tlast marks the last tree byte and asks for a
// load status word. Result words: m_tdata symbol, m_tuser kind, m_tlast on
// the last result of an input word.
// Each byte is consumed one bit per step. A data bit reads the child from
// node memory, then checks it for a leaf; a data byte ends with a flush of
// the pending symbol. A tree bit that adds a node writes it, links it to its
// parent and may then reload the stack top. A final tree byte adds a status
// word. Clear and unused modes return straight to idle. One word is worked
// at a time; s_tready is high only between words. The result register is
// free again in the cycle m_tready takes it; while the receiver stalls,
// decoding holds at the next leaf found.
// Reset empties the tree and the walk; node and stack memory need no clear.
// ----------------------------------------------------------------------------
module huffman_tree_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic [1:0] s_tuser,   // mode
    input  logic       s_tlast,   // final_tree_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // symbol
    output logic [1:0] m_tuser,   // kind
    output logic       m_tlast    // run_end
);
    import hufd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BIT, S_LINK, S_POP, S_FIN, S_FINRD, S_STAT, S_WALK, S_WALK2, S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK, PH_LEAF, PH_DONE, PH_CLOSED
    } phase_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           shift_reg, shift_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic                 fin_reg, fin_next;
    logic [2:0]           leaf_cnt_reg, leaf_cnt_next;
    logic [7:0]           leaf_acc_reg, leaf_acc_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [STK_W-1:0]     top_reg, top_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 int_reg, int_next;
    logic                 ready_reg, ready_next;
    logic [ENTRY_W-1:0]   cur_reg, cur_next;
    logic [ENTRY_W-1:0]   root_reg, root_next;
    logic [IDX_W-1:0]     child_reg, child_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_sym_reg, pend_sym_next;
    kind_t                kind_reg, kind_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_sym_reg, m_sym_next;
    kind_t                m_kind_reg, m_kind_next;
    logic                 m_last_reg, m_last_next;

    logic                 node_we;
    logic [NODE_AW-1:0]   node_waddr, node_raddr;
    logic [ENTRY_W-1:0]   node_wdata, node_rdata;
    logic                 stk_we;
    logic [STACK_AW-1:0]  stk_waddr, stk_raddr;
    logic [STK_W-1:0]     stk_wdata, stk_rdata;

    logic                 s_fire, out_free, bit_val, last_bit, popped;
    logic [7:0]           acc_shift;
    logic [LEVEL_W-1:0]   lvl_m1, lvl_m2;
    logic [STK_W-1:0]     top_upd;
    logic [IDX_W-1:0]     child_sel;

    hufd_ram #(.WIDTH(ENTRY_W), .DEPTH(NODE_SLOTS)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    hufd_ram #(.WIDTH(STK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign bit_val  = shift_reg[7];
    assign last_bit = (bit_cnt_reg == 3'd7);
    assign acc_shift = {leaf_acc_reg[6:0], bit_val};
    assign lvl_m1   = level_reg - LEVEL_W'(1);
    assign lvl_m2   = level_reg - LEVEL_W'(2);
    assign popped   = (level_reg != '0) && top_reg[STK_W-1];
    assign top_upd  = top_reg[STK_W-1] ? top_reg : {1'b1, idx_reg, top_reg[IDX_W-1:0]};
    assign child_sel = bit_val ? cur_reg[IDX_W-1:0] : cur_reg[2*IDX_W-1:IDX_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        fin_next        = fin_reg;
        leaf_cnt_next   = leaf_cnt_reg;
        leaf_acc_next   = leaf_acc_reg;
        used_next       = used_reg;
        level_next      = level_reg;
        top_next        = top_reg;
        idx_next        = idx_reg;
        int_next        = int_reg;
        ready_next      = ready_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        child_next      = child_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        kind_next       = kind_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_sym_next      = m_sym_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        node_we         = 1'b0;
        node_waddr      = idx_reg;
        node_wdata      = '0;
        node_raddr      = child_reg;
        stk_we          = 1'b0;
        stk_waddr       = lvl_m1[STACK_AW-1:0];
        stk_wdata       = top_upd;
        stk_raddr       = lvl_m2[STACK_AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    shift_next   = s_tdata;
                    bit_cnt_next = '0;
                    fin_next     = s_tlast;
                    case (s_tuser)
                        MODE_TREE: state_next = S_BIT;
                        MODE_DATA: begin
                            if (ready_reg) begin
                                state_next = S_WALK;
                            end else begin
                                kind_next  = KIND_NO_TREE;
                                state_next = S_STAT;
                            end
                        end
                        MODE_CLEAR: begin
                            phase_next    = PH_MARK;
                            used_next     = '0;
                            level_next    = '0;
                            leaf_cnt_next = '0;
                            leaf_acc_next = '0;
                            ready_next    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_BIT: begin
                logic add;
                logic [ENTRY_W-1:0] entry;
                add   = 1'b0;
                entry = '0;
                case (phase_reg)
                    PH_MARK: begin
                        if (bit_val) begin
                            phase_next    = PH_LEAF;
                            leaf_cnt_next = '0;
                            leaf_acc_next = '0;
                        end else begin
                            add = 1'b1;
                        end
                    end
                    PH_LEAF: begin
                        leaf_acc_next = acc_shift;
                        if (leaf_cnt_reg == 3'd7) begin
                            leaf_cnt_next = '0;
                            phase_next    = PH_MARK;
                            add           = 1'b1;
                            entry         = {1'b1, (ENTRY_W-9)'(0), acc_shift};
                        end else begin
                            leaf_cnt_next = leaf_cnt_reg + 3'd1;
                        end
                    end
                    default: ;
                endcase
                if (add && used_reg < USED_W'(NODE_SLOTS)) begin
                    node_we    = 1'b1;
                    node_waddr = used_reg[NODE_AW-1:0];
                    node_wdata = entry;
                    idx_next   = IDX_W'(used_reg);
                    int_next   = !entry[ENTRY_W-1];
                    used_next  = used_reg + USED_W'(1);
                    state_next = S_LINK;
                end else begin
                    if (add) begin
                        phase_next = PH_CLOSED;
                    end
                    if (last_bit) begin
                        state_next = fin_reg ? S_FIN : S_IDLE;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        shift_next   = {shift_reg[6:0], 1'b0};
                    end
                end
            end
            S_LINK: begin
                logic adv;
                adv = 1'b1;
                if (level_reg != '0) begin
                    node_we    = 1'b1;
                    node_waddr = top_reg[NODE_AW-1:0];
                    node_wdata = top_reg[STK_W-1]
                               ? {1'b0, top_reg[2*IDX_W-1:IDX_W], idx_reg}
                               : {1'b0, idx_reg, (IDX_W)'(0)};
                end
                if (int_reg) begin
                    if (!popped && level_reg >= LEVEL_W'(STACK_DEPTH)) begin
                        phase_next = PH_CLOSED;
                        top_next   = top_upd;
                    end else if (popped) begin
                        top_next = {1'b0, (IDX_W)'(0), idx_reg};
                    end else begin
                        stk_we     = (level_reg != '0);
                        top_next   = {1'b0, (IDX_W)'(0), idx_reg};
                        level_next = level_reg + LEVEL_W'(1);
                    end
                end else if (popped) begin
                    level_next = lvl_m1;
                    if (lvl_m1 == '0) begin
                        phase_next = PH_DONE;
                    end else begin
                        adv        = 1'b0;
                        state_next = S_POP;
                    end
                end else begin
                    top_next = top_upd;
                    if (level_reg == '0) begin
                        phase_next = PH_DONE;
                    end
                end
                if (adv) begin
                    if (last_bit) begin
                        state_next = fin_reg ? S_FIN : S_IDLE;
                    end else begin
                        state_next   = S_BIT;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        shift_next   = {shift_reg[6:0], 1'b0};
                    end
                end
            end
            S_POP: begin
                top_next = stk_rdata;
                if (last_bit) begin
                    state_next = fin_reg ? S_FIN : S_IDLE;
                end else begin
                    state_next   = S_BIT;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    shift_next   = {shift_reg[6:0], 1'b0};
                end
            end
            S_FIN: begin
                node_raddr = '0;
                if (phase_reg == PH_DONE && used_reg != '0) begin
                    state_next = S_FINRD;
                end else begin
                    kind_next  = KIND_TREE_BAD;
                    phase_next = PH_CLOSED;
                    ready_next = 1'b0;
                    state_next = S_STAT;
                end
            end
            S_FINRD: begin
                root_next = node_rdata;
                cur_next  = node_rdata;
                if (node_rdata[ENTRY_W-1]) begin
                    kind_next  = KIND_TREE_BAD;
                    phase_next = PH_CLOSED;
                    ready_next = 1'b0;
                end else begin
                    kind_next  = KIND_TREE_OK;
                    ready_next = 1'b1;
                end
                state_next = S_STAT;
            end
            S_STAT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = '0;
                    m_kind_next  = kind_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK: begin
                node_raddr = child_sel[NODE_AW-1:0];
                child_next = child_sel;
                state_next = S_WALK2;
            end
            S_WALK2: begin
                if (!(node_rdata[ENTRY_W-1] && pend_valid_reg && !out_free)) begin
                    if (node_rdata[ENTRY_W-1]) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_sym_next   = pend_sym_reg;
                            m_kind_next  = KIND_SYMBOL;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = node_rdata[7:0];
                        cur_next        = root_reg;
                    end else begin
                        cur_next = node_rdata;
                    end
                    if (last_bit) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next   = S_WALK;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        shift_next   = {shift_reg[6:0], 1'b0};
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_sym_next      = pend_sym_reg;
                    m_kind_next     = KIND_SYMBOL;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_MARK;
            bit_cnt_reg    <= '0;
            leaf_cnt_reg   <= '0;
            leaf_acc_reg   <= '0;
            used_reg       <= '0;
            level_reg      <= '0;
            ready_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            leaf_cnt_reg   <= leaf_cnt_next;
            leaf_acc_reg   <= leaf_acc_next;
            used_reg       <= used_next;
            level_reg      <= level_next;
            ready_reg      <= ready_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        shift_reg    <= shift_next;
        fin_reg      <= fin_next;
        top_reg      <= top_next;
        idx_reg      <= idx_next;
        int_reg      <= int_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        child_reg    <= child_next;
        pend_sym_reg <= pend_sym_next;
        kind_reg     <= kind_next;
        m_sym_reg    <= m_sym_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
    end

endmodule
